// File: hdl/cliw_pkg.sv
// cliw_pkg: shared types and constants for the character lcd i2c writer
// holds the command queue entry, config struct, bus op codes and sequencer phases
// no dependencies
package cliw_pkg;

  localparam int unsigned QueueDepth = 2;

  // expander bit positions
  localparam logic [7:0] BitRs = 8'h01;
  localparam logic [7:0] BitEn = 8'h04;
  localparam logic [7:0] BitBl = 8'h08;

  // character codes
  localparam logic [7:0] ChClear     = 8'h0C;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChBackspace = 8'h08;

  // lcd commands
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdShiftLeft = 8'h10;
  localparam logic [7:0] CmdDdram     = 8'h80;

  // ddram row bases
  localparam logic [7:0] RowBase2 = 8'h40;
  localparam logic [7:0] RowBase3 = 8'h14;
  localparam logic [7:0] RowBase4 = 8'h54;

  // reset values of the config registers
  localparam logic       RstBacklight = 1'b1;
  localparam logic [2:0] RstRows      = 3'd4;
  localparam logic [4:0] RstColumns   = 5'd20;
  localparam logic [7:0] RstSlaveAddr = 8'h4E;
  localparam logic [2:0] RstCurRow    = 3'd1;

  typedef enum logic [1:0] {
    REG_BACKLIGHT = 2'd0,
    REG_ROWS      = 2'd1,
    REG_COLUMNS   = 2'd2,
    REG_SLAVE     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WRITE = 2'd1,
    OP_STOP  = 2'd2
  } bus_op_t;

  typedef enum logic [3:0] {
    PH_START,
    PH_ADDR,
    PH_HI0,
    PH_HI1,
    PH_HI2,
    PH_LO0,
    PH_LO1,
    PH_LO2,
    PH_STOP
  } phase_t;

  typedef struct packed {
    logic       backlight;
    logic [2:0] rows;
    logic [4:0] columns;
    logic [7:0] slave_addr;
  } cfg_t;

  // one lcd byte waiting to be sent
  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       rs;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
    cmd_t head;
  } q_status_t;

endpackage

// File: hdl/cliw_front.sv
// cliw_front: accepts input transactions, decodes them into one lcd byte each
// and tracks the current row; depends on cliw_pkg
module cliw_front (
  input  logic           clk,
  input  logic           rst_n,
  input  cliw_pkg::cfg_t cfg,
  input  logic           in_valid,
  input  logic           in_mode,
  input  logic [7:0]     in_character,
  input  logic [7:0]     in_column,
  input  logic [7:0]     in_row,
  input  logic           q_full,
  output logic           push,
  output cliw_pkg::cmd_t push_cmd
);
  import cliw_pkg::*;

  logic [2:0] cur_row_r, cur_row_nxt;
  logic [3:0] row_inc;
  logic [2:0] nl_row;
  logic [7:0] goto_col, goto_row;
  logic [2:0] row_clamp;
  logic [4:0] col_clamp;
  logic [7:0] row_base;
  logic [7:0] goto_byte;

  assign push = in_valid && !q_full;

  // newline wraps once past the row count
  always_comb begin
    row_inc = {1'b0, cur_row_r} + 4'd1;
    if (row_inc > {1'b0, cfg.rows}) begin
      nl_row = 3'd1;
    end else begin
      nl_row = row_inc[2:0];
    end
  end

  always_comb begin
    if (in_mode) begin
      goto_col = in_column;
      goto_row = in_row;
    end else begin
      goto_col = 8'd1;
      goto_row = {5'd0, nl_row};
    end
  end

  always_comb begin
    if (goto_row > {5'd0, cfg.rows}) begin
      row_clamp = cfg.rows;
    end else begin
      row_clamp = goto_row[2:0];
    end
    if (goto_col > {3'd0, cfg.columns}) begin
      col_clamp = cfg.columns;
    end else begin
      col_clamp = goto_col[4:0];
    end
    case (row_clamp)
      3'd2:    row_base = RowBase2;
      3'd3:    row_base = RowBase3;
      3'd4:    row_base = RowBase4;
      default: row_base = 8'h00;
    endcase
    // column zero lands one below the row base
    goto_byte = CmdDdram | (row_base + {3'd0, col_clamp} - 8'd1);
  end

  always_comb begin
    cur_row_nxt       = cur_row_r;
    push_cmd.cmd_byte = goto_byte;
    push_cmd.rs       = 1'b0;
    if (!in_mode) begin
      case (in_character)
        ChClear: begin
          push_cmd.cmd_byte = CmdClear;
          cur_row_nxt       = RstCurRow;
        end
        ChNewline: begin
          cur_row_nxt = nl_row;
        end
        ChBackspace: begin
          push_cmd.cmd_byte = CmdShiftLeft;
        end
        default: begin
          push_cmd.cmd_byte = in_character;
          push_cmd.rs       = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= RstCurRow;
    end else if (push) begin
      cur_row_r <= cur_row_nxt;
    end
  end

endmodule

// File: hdl/cliw_queue.sv
// cliw_queue: short fifo of decoded lcd bytes between front and back
// depends on cliw_pkg
module cliw_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cliw_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output cliw_pkg::q_status_t status
);
  import cliw_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            entry_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == CntW'(QueueDepth));
  assign status.head  = entry_r[rd_ptr_r];

endmodule

// File: hdl/cliw_back.sv
// cliw_back: expands one lcd byte into nine i2c bus transactions
// sequencer plus output register; depends on cliw_pkg
module cliw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cliw_pkg::cfg_t      cfg,
  input  cliw_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_bus_op,
  output logic [7:0]          out_bus_byte,
  output logic                out_last
);
  import cliw_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;
  bus_op_t    op_r, op_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       load;
  logic [7:0] nib_base_hi, nib_base_lo;

  // output register frees up when empty or being taken
  assign load = q_status.valid && (!out_valid_r || !out_stall);

  always_comb begin
    nib_base_hi = {q_status.head.cmd_byte[7:4], 4'd0} | (cfg.backlight ? BitBl : 8'h00)
                  | (q_status.head.rs ? BitRs : 8'h00);
    nib_base_lo = {q_status.head.cmd_byte[3:0], 4'd0} | (cfg.backlight ? BitBl : 8'h00)
                  | (q_status.head.rs ? BitRs : 8'h00);
  end

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      op_nxt        = OP_WRITE;
      last_nxt      = 1'b0;
      byte_nxt      = 8'h00;
      case (phase_r)
        PH_START: begin
          op_nxt    = OP_START;
          phase_nxt = PH_ADDR;
        end
        PH_ADDR: begin
          byte_nxt  = cfg.slave_addr;
          phase_nxt = PH_HI0;
        end
        PH_HI0: begin
          byte_nxt  = nib_base_hi;
          phase_nxt = PH_HI1;
        end
        PH_HI1: begin
          byte_nxt  = nib_base_hi | BitEn;
          phase_nxt = PH_HI2;
        end
        PH_HI2: begin
          byte_nxt  = nib_base_hi;
          phase_nxt = PH_LO0;
        end
        PH_LO0: begin
          byte_nxt  = nib_base_lo;
          phase_nxt = PH_LO1;
        end
        PH_LO1: begin
          byte_nxt  = nib_base_lo | BitEn;
          phase_nxt = PH_LO2;
        end
        PH_LO2: begin
          byte_nxt  = nib_base_lo;
          phase_nxt = PH_STOP;
        end
        PH_STOP: begin
          op_nxt    = OP_STOP;
          last_nxt  = 1'b1;
          pop       = 1'b1;
          phase_nxt = PH_START;
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_bus_op   = op_r;
  assign out_bus_byte = byte_r;
  assign out_last     = last_r;

  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && last_r) |-> (op_r == OP_STOP))
    else $error("last flag on a transaction that is not a stop");

  a_pop_at_stop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (phase_r == PH_STOP && q_status.valid))
    else $error("queue popped before the stop transaction");

  a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
    (load && phase_r == PH_START) |=> (out_valid_r && op_r == OP_START && byte_r == 8'h00))
    else $error("sequence did not open with a start");

endmodule

// File: hdl/character_lcd_i2c_writer.sv
// character_lcd_i2c_writer: top level, config registers plus front, queue and back
// depends on cliw_pkg, cliw_front, cliw_queue, cliw_back
//
//   port group | direction | transaction
//   in_*       | input     | one character or goto request (mode, character, column, row)
//   out_*      | output    | one i2c bus step (bus_op, bus_byte, last)
//   cfg_*      | input     | register write (index, data), no read-back
//
// every input causes nine output transactions, one per cycle unless out_stall holds them;
// the back sequencer finishes all nine for one input before it starts on the next
// the front decodes an input in the cycle it is accepted; a 2-entry queue lets it
// take new input while the back is stalled or busy
// the first output is loaded into the back's output register after the queue holds the item
// rst_n is synchronous: config returns to its defaults, current row to 1, queue empties
module character_lcd_i2c_writer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_character,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_bus_op,
  output logic [7:0] out_bus_byte,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);
  import cliw_pkg::*;

  cfg_t      cfg_r;
  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backlight  <= RstBacklight;
      cfg_r.rows       <= RstRows;
      cfg_r.columns    <= RstColumns;
      cfg_r.slave_addr <= RstSlaveAddr;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_BACKLIGHT: cfg_r.backlight  <= cfg_wdata[0];
        REG_ROWS:      cfg_r.rows       <= cfg_wdata[2:0];
        REG_COLUMNS:   cfg_r.columns    <= cfg_wdata[4:0];
        REG_SLAVE:     cfg_r.slave_addr <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = q_status.full;

  cliw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_mode      (in_mode),
    .in_character (in_character),
    .in_column    (in_column),
    .in_row       (in_row),
    .q_full       (q_status.full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  cliw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .status   (q_status)
  );

  cliw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bus_op   (out_bus_op),
    .out_bus_byte (out_bus_byte),
    .out_last     (out_last)
  );

endmodule

// File: test/testbench.sv
// testbench for character_lcd_i2c_writer: predicts the nine i2c bus steps of every request
// and checks each output transaction in order, under several idle and stall mixes
// depends on cliw_pkg and the character_lcd_i2c_writer rtl
module testbench;
  import cliw_pkg::*;

  localparam int StallLimit = 2000;

  typedef struct {
    bus_op_t    op;
    logic [7:0] data;
    logic       last;
  } bus_step_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_mode;
  logic [7:0] in_character;
  logic [7:0] in_column;
  logic [7:0] in_row;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_bus_op;
  logic [7:0] out_bus_byte;
  logic       out_last;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;

  // predictor copy of the registers and the row counter
  logic       cfg_backlight = RstBacklight;
  logic [2:0] cfg_rows      = RstRows;
  logic [4:0] cfg_columns   = RstColumns;
  logic [7:0] cfg_slave     = RstSlaveAddr;
  logic [2:0] lcd_row       = RstCurRow;

  bus_step_t pending_steps[$];
  int        error_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  character_lcd_i2c_writer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_character (in_character),
    .in_column    (in_column),
    .in_row       (in_row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bus_op   (out_bus_op),
    .out_bus_byte (out_bus_byte),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ddram set-address command after row and column clamping
  function automatic logic [7:0] ddram_cmd(logic [7:0] col, logic [7:0] row);
    logic [7:0] r;
    logic [7:0] c;
    logic [7:0] base;
    r = (row > cfg_rows) ? {5'd0, cfg_rows} : row;
    c = (col > cfg_columns) ? {3'd0, cfg_columns} : col;
    case (r)
      8'd2:    base = RowBase2;
      8'd3:    base = RowBase3;
      8'd4:    base = RowBase4;
      default: base = 8'h00;
    endcase
    return CmdDdram | (base + c - 8'd1);
  endfunction

  // start, address, two nibbles of three expander writes, stop
  function automatic void push_lcd_byte(logic [7:0] value, logic rs);
    logic [7:0] flags;
    logic [7:0] nib_byte;
    flags = (rs ? BitRs : 8'h00) | (cfg_backlight ? BitBl : 8'h00);
    pending_steps.push_back('{OP_START, 8'h00, 1'b0});
    pending_steps.push_back('{OP_WRITE, cfg_slave, 1'b0});
    for (int n = 1; n >= 0; n--) begin
      nib_byte = {value[n*4 +: 4], 4'h0} | flags;
      pending_steps.push_back('{OP_WRITE, nib_byte, 1'b0});
      pending_steps.push_back('{OP_WRITE, nib_byte | BitEn, 1'b0});
      pending_steps.push_back('{OP_WRITE, nib_byte & ~BitEn, 1'b0});
    end
    pending_steps.push_back('{OP_STOP, 8'h00, 1'b1});
  endfunction

  function automatic void predict_request(logic mode, logic [7:0] ch, logic [7:0] col,
                                          logic [7:0] row);
    logic [3:0] next_row;
    if (mode) begin
      push_lcd_byte(ddram_cmd(col, row), 1'b0);
    end else begin
      case (ch)
        ChClear: begin
          lcd_row = RstCurRow;
          push_lcd_byte(CmdClear, 1'b0);
        end
        ChNewline: begin
          // wrap compare on the wide value, then keep three bits
          next_row = {1'b0, lcd_row} + 4'd1;
          if (next_row > {1'b0, cfg_rows}) next_row = 4'd1;
          lcd_row = next_row[2:0];
          push_lcd_byte(ddram_cmd(8'd1, {5'd0, lcd_row}), 1'b0);
        end
        ChBackspace: push_lcd_byte(CmdShiftLeft, 1'b0);
        default:     push_lcd_byte(ch, 1'b1);
      endcase
    end
  endfunction

  task automatic send_request(logic mode, logic [7:0] ch, logic [7:0] col, logic [7:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_character <= ch;
    in_column    <= col;
    in_row       <= row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(mode, ch, col, row);
  endtask

  // drop in_valid and wait until every expected step has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] bl, logic [7:0] rows, logic [7:0] cols,
                              logic [7:0] slave);
    reg_idx_t   order[4];
    logic [7:0] values[4];
    order  = '{REG_BACKLIGHT, REG_ROWS, REG_COLUMNS, REG_SLAVE};
    values = '{bl, rows, cols, slave};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= values[i];
      @(posedge clk);
    end
    cfg_we        <= 1'b0;
    cfg_backlight = bl[0];
    cfg_rows      = rows[2:0];
    cfg_columns   = cols[4:0];
    cfg_slave     = slave;
  endtask

  task automatic test_directed_defaults();
    send_request(1'b0, 8'h00, 8'hFF, 8'hFF);
    send_request(1'b0, 8'hFF, 8'h00, 8'h00);
    send_request(1'b0, 8'h41, 8'h5A, 8'hA5);
    send_request(1'b0, ChBackspace, 8'h00, 8'h00);
    // newline walks the rows and wraps back to the first
    repeat (5) send_request(1'b0, ChNewline, 8'h00, 8'h00);
    send_request(1'b0, ChClear, 8'hFF, 8'hFF);
    send_request(1'b0, ChNewline, 8'h00, 8'h00);
    send_request(1'b1, 8'h00, 8'd1, 8'd1);
    send_request(1'b1, 8'hFF, 8'd20, 8'd4);
    send_request(1'b1, 8'h00, 8'd255, 8'd255);
    // column zero gives base minus one
    send_request(1'b1, 8'h00, 8'd0, 8'd0);
    send_request(1'b1, 8'h00, 8'd0, 8'd2);
    send_request(1'b1, 8'h00, 8'd1, 8'd3);
    send_request(1'b1, ChClear, 8'd5, 8'd2);
    send_request(1'b1, ChNewline, 8'd21, 8'd5);
    send_request(1'b0, ChNewline, 8'h00, 8'h00);
    drain();
  endtask

  task automatic test_config_extremes();
    // no rows, no columns, no backlight
    apply_config(8'h00, 8'h00, 8'h00, 8'h00);
    send_request(1'b0, ChNewline, 8'h00, 8'h00);
    send_request(1'b0, ChNewline, 8'h00, 8'h00);
    send_request(1'b1, 8'h00, 8'd0, 8'd0);
    send_request(1'b1, 8'h00, 8'd255, 8'd255);
    send_request(1'b0, 8'hA5, 8'h00, 8'h00);
    // widest register values, rows beyond four
    apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    repeat (8) send_request(1'b0, ChNewline, 8'h00, 8'h00);
    send_request(1'b1, 8'h00, 8'd255, 8'd255);
    send_request(1'b1, 8'h00, 8'd31, 8'd5);
    send_request(1'b1, 8'h00, 8'd0, 8'd7);
    send_request(1'b0, 8'h5A, 8'h00, 8'h00);
    // single row and column
    apply_config(8'h01, 8'h01, 8'h01, 8'h4E);
    send_request(1'b0, ChNewline, 8'h00, 8'h00);
    send_request(1'b1, 8'h00, 8'd255, 8'd3);
    send_request(1'b0, ChClear, 8'h00, 8'h00);
    send_request(1'b0, ChBackspace, 8'h00, 8'h00);
    drain();
  endtask

  task automatic test_random_traffic();
    int         idle_mix[4];
    int         stall_mix[4];
    logic       mode;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] rows_val;
    logic [7:0] cols_val;
    idle_mix  = '{0, 51, 0, 6};
    stall_mix = '{0, 0, 51, 6};
    for (int ph = 0; ph < 4; ph++) begin
      for (int set = 0; set < 2; set++) begin
        rows_val = 8'($urandom_range(255));
        cols_val = 8'($urandom_range(255));
        // mostly usable geometry, upper bits still random
        if ($urandom_range(3) != 0) rows_val[2:0] = 3'($urandom_range(1, 4));
        if ($urandom_range(3) != 0) cols_val[4:0] = 5'($urandom_range(1, 20));
        apply_config(8'($urandom_range(255)), rows_val, cols_val, 8'($urandom_range(255)));
        send_idle_pct = idle_mix[ph];
        stall_pct     = stall_mix[ph];
        repeat (12) begin
          mode = 1'($urandom_range(1));
          case ($urandom_range(9))
            0:       ch = ChClear;
            1:       ch = ChNewline;
            2:       ch = ChBackspace;
            default: ch = 8'($urandom_range(255));
          endcase
          col = ($urandom_range(1) != 0) ? 8'($urandom_range(21)) : 8'($urandom_range(255));
          row = ($urandom_range(1) != 0) ? 8'($urandom_range(5)) : 8'($urandom_range(255));
          send_request(mode, ch, col, row);
        end
      end
    end
    send_idle_pct = 0;
    drain();
    stall_pct = 0;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_outputs
    bus_step_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_steps.size() == 0) begin
        $error("unexpected output transaction: bus_op %0d, bus_byte %0h", out_bus_op,
               out_bus_byte);
        error_count++;
      end else begin
        want = pending_steps.pop_front();
        if (out_bus_op !== want.op) begin
          $error("bus_op: expected %0d, actual %0d", want.op, out_bus_op);
          error_count++;
        end
        if (out_bus_byte !== want.data) begin
          $error("bus_byte: expected %0h, actual %0h", want.data, out_bus_byte);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("** character_lcd_i2c_writer: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= 1'b0;
    in_character <= 8'h00;
    in_column    <= 8'h00;
    in_row       <= 8'h00;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_BACKLIGHT;
    cfg_wdata    <= 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_defaults();
    test_config_extremes();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_steps.size() == 0) begin
      $display("** character_lcd_i2c_writer: PASSED **");
    end else begin
      $display("** character_lcd_i2c_writer: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/cliw_pkg.sv
hdl/cliw_front.sv
hdl/cliw_queue.sv
hdl/cliw_back.sv
hdl/character_lcd_i2c_writer.sv
test/testbench.sv
